>>> sv/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared constants, types and state encoding for the piecewise-linear
// time lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int SPAN_W      = DATA_W + 1;
  localparam int ALPHA_W     = FRAC_BITS + 1;
  localparam int PROD_W      = SPAN_W + ALPHA_W + 1;
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_RD_LAST,
    ST_CHK_LAST,
    ST_SEARCH,
    ST_SEARCH_CHK,
    ST_SPAN,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] time_val;
    logic [DATA_W-1:0] value_val;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic [DATA_W-1:0] time_val;
    logic [DATA_W-1:0] value_val;
  } tbl_data_t;

  typedef struct packed {
    logic              start;
    logic [SPAN_W-1:0] offset;
    logic [SPAN_W-1:0] span;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/piecewise_linear_time_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_time_lookup
// Breakpoint table with clamped, linearly interpolated lookup by time.
// Write transaction: accepted back to back while no query is in progress, no result.
// Query steps: an empty table goes straight to the result; otherwise the first
// and last breakpoints are read for the clamps, then interpolation runs a binary
// search (8 memory reads at most), the bit-serial divider, one multiply, one add.
// One query at a time; input stalls until its result is loaded.
// Reset (synchronous, rst_n low) clears control and points_in_use; the table
// contents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_time_lookup (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic [plt_pkg::INDEX_W-1:0]  in_point_index,
  input  wire logic signed [plt_pkg::DATA_W-1:0] in_point_time,
  input  wire logic signed [plt_pkg::DATA_W-1:0] in_point_value,
  input  wire logic signed [plt_pkg::DATA_W-1:0] in_query_time,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_ok,
  output logic signed [plt_pkg::DATA_W-1:0] out_result_value,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [plt_pkg::COUNT_W-1:0]  cfg_points_in_use
);
  import plt_pkg::*;

  state_t                    state_r, state_nxt;
  logic [COUNT_W-1:0]        npts_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic signed [DATA_W-1:0]  out_value_r, out_value_nxt;
  logic signed [DATA_W-1:0]  q_r, q_nxt;
  logic signed [DATA_W-1:0]  t_lo_r, t_lo_nxt, v_lo_r, v_lo_nxt;
  logic signed [DATA_W-1:0]  t_hi_r, t_hi_nxt, v_hi_r, v_hi_nxt;
  logic [ADDR_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [ADDR_W-1:0]         last_r, last_nxt;
  logic [ALPHA_W-1:0]        alpha_r, alpha_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      ok_r, ok_nxt;
  logic signed [DATA_W-1:0]  res_r, res_nxt;

  tbl_wr_t                   wr;
  tbl_rd_t                   rd;
  tbl_data_t                 rd_data;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic                      in_acc;
  logic signed [DATA_W-1:0]  rd_time, rd_value;
  logic signed [SPAN_W-1:0]  span_w, offset_w, diff_w;
  logic [ADDR_W:0]           mid_sum;
  logic signed [PROD_W-1:0]  sum_w;
  logic [COUNT_W-1:0]        npts_m1;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_time   = $signed(rd_data.time_val);
  assign rd_value  = $signed(rd_data.value_val);
  assign npts_m1   = npts_r - COUNT_W'(1);

  assign wr.en        = in_acc && (in_op == OP_WRITE)
                        && (int'(in_point_index) < TABLE_DEPTH);
  assign wr.addr      = ADDR_W'(in_point_index);
  assign wr.time_val  = in_point_time;
  assign wr.value_val = in_point_value;

  plt_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  plt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      npts_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        npts_r <= cfg_points_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
    q_r         <= q_nxt;
    t_lo_r      <= t_lo_nxt;
    v_lo_r      <= v_lo_nxt;
    t_hi_r      <= t_hi_nxt;
    v_hi_r      <= v_hi_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    last_r      <= last_nxt;
    alpha_r     <= alpha_nxt;
    prod_r      <= prod_nxt;
    ok_r        <= ok_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    span_w   = SPAN_W'(t_hi_r) - SPAN_W'(t_lo_r);
    offset_w = SPAN_W'(q_r) - SPAN_W'(t_lo_r);
    diff_w   = SPAN_W'(v_hi_r) - SPAN_W'(v_lo_r);
    mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
    sum_w    = PROD_W'(v_lo_r) + (prod_r >>> FRAC_BITS);

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    q_nxt         = q_r;
    t_lo_nxt      = t_lo_r;
    v_lo_nxt      = v_lo_r;
    t_hi_nxt      = t_hi_r;
    v_hi_nxt      = v_hi_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    last_nxt      = last_r;
    alpha_nxt     = alpha_r;
    prod_nxt      = prod_r;
    ok_nxt        = ok_r;
    res_nxt       = res_r;
    rd.en         = 1'b0;
    rd.addr       = '0;
    div_req.start  = 1'b0;
    div_req.offset = offset_w;
    div_req.span   = span_w;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_QUERY)) begin
          q_nxt  = in_query_time;
          ok_nxt = 1'b1;
          if (int'(npts_r) >= TABLE_DEPTH) begin
            last_nxt = ADDR_W'(TABLE_DEPTH - 1);
          end else begin
            last_nxt = npts_m1[ADDR_W-1:0];
          end
          if (npts_r == '0) begin
            ok_nxt    = 1'b0;
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RD_FIRST;
          end
        end
      end
      ST_RD_FIRST: begin
        rd.en     = 1'b1;
        rd.addr   = '0;
        state_nxt = ST_CHK_FIRST;
      end
      ST_CHK_FIRST: begin
        t_lo_nxt = rd_time;
        v_lo_nxt = rd_value;
        if (q_r <= rd_time) begin
          res_nxt   = rd_value;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD_LAST;
        end
      end
      ST_RD_LAST: begin
        rd.en     = 1'b1;
        rd.addr   = last_r;
        state_nxt = ST_CHK_LAST;
      end
      ST_CHK_LAST: begin
        t_hi_nxt = rd_time;
        v_hi_nxt = rd_value;
        lo_nxt   = '0;
        hi_nxt   = last_r;
        if (q_r >= rd_time) begin
          res_nxt   = rd_value;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if ({1'b0, hi_r} > ({1'b0, lo_r} + (ADDR_W + 1)'(1))) begin
          mid_nxt   = mid_sum[ADDR_W:1];
          rd.en     = 1'b1;
          rd.addr   = mid_sum[ADDR_W:1];
          state_nxt = ST_SEARCH_CHK;
        end else begin
          state_nxt = ST_SPAN;
        end
      end
      ST_SEARCH_CHK: begin
        if (rd_time <= q_r) begin
          lo_nxt   = mid_r;
          t_lo_nxt = rd_time;
          v_lo_nxt = rd_value;
        end else begin
          hi_nxt   = mid_r;
          t_hi_nxt = rd_time;
          v_hi_nxt = rd_value;
        end
        state_nxt = ST_SEARCH;
      end
      ST_SPAN: begin
        priority if (span_w <= 0) begin
          res_nxt   = v_lo_r;
          state_nxt = ST_DONE;
        end else if (offset_w <= 0) begin
          alpha_nxt = '0;
          state_nxt = ST_MUL;
        end else if (offset_w >= span_w) begin
          alpha_nxt = ALPHA_W'(1) << FRAC_BITS;
          state_nxt = ST_MUL;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          alpha_nxt = {1'b0, div_rsp.quot};
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = diff_w * $signed({1'b0, alpha_r});
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        res_nxt   = sum_w[DATA_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_result_value = out_value_r;

endmodule

`default_nettype wire

>>> sv/plt_table.sv
// ----------------------------------------------------------------------------
// plt_table
// Breakpoint storage: time and value memories with one write port and one
// registered read port at a shared address.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_table (
  input  wire logic              clk,
  input  wire plt_pkg::tbl_wr_t  wr,
  input  wire plt_pkg::tbl_rd_t  rd,
  output plt_pkg::tbl_data_t     rd_data
);
  import plt_pkg::*;

  logic [DATA_W-1:0] time_mem  [TABLE_DEPTH];
  logic [DATA_W-1:0] value_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      time_mem[wr.addr]  <= wr.time_val;
      value_mem[wr.addr] <= wr.value_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data.time_val  <= time_mem[rd.addr];
      rd_data.value_val <= value_mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/plt_div.sv
// ----------------------------------------------------------------------------
// plt_div
// Restoring fraction divider: one quotient bit per cycle, giving
// (offset << FRAC_BITS) / span for 0 < offset < span.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plt_pkg::div_req_t req,
  output plt_pkg::div_rsp_t      rsp
);
  import plt_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SPAN_W-1:0]    rem_r, rem_nxt;
  logic [SPAN_W-1:0]    span_r, span_nxt;
  logic [FRAC_BITS-1:0] quot_r, quot_nxt;
  logic [SPAN_W:0]      shifted;
  logic [SPAN_W:0]      reduced;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    quot_r <= quot_nxt;
  end

  always_comb begin
    shifted  = {rem_r, 1'b0};
    reduced  = shifted - {1'b0, span_r};
    fits     = (shifted >= {1'b0, span_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    span_nxt = span_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(FRAC_BITS);
      rem_nxt  = req.offset;
      span_nxt = req.span;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? reduced[SPAN_W-1:0] : shifted[SPAN_W-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], fits};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

>>> sv/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// Port-level assertions for the piecewise-linear time lookup block, bound
// to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         in_op,
  input wire logic [plt_pkg::INDEX_W-1:0]  in_point_index,
  input wire logic signed [plt_pkg::DATA_W-1:0] in_point_time,
  input wire logic signed [plt_pkg::DATA_W-1:0] in_point_value,
  input wire logic signed [plt_pkg::DATA_W-1:0] in_query_time,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_ok,
  input wire logic signed [plt_pkg::DATA_W-1:0] out_result_value,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [plt_pkg::COUNT_W-1:0]  cfg_points_in_use
);
  import plt_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_point_index, in_point_time, in_point_value, in_query_time,
                       cfg_valid, cfg_ready, cfg_points_in_use};

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_result_value))
    else $error("stalled result transaction changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_result_value == '0)
    else $error("not-ok result carries a nonzero value");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_WRITE) |=> !in_stall)
    else $error("write transaction left the input stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_QUERY) |=> in_stall)
    else $error("query transaction did not stall the input");

endmodule

bind piecewise_linear_time_lookup plt_checker u_plt_checker (.*);

`default_nettype wire

>>> verif/tb_piecewise_linear_time_lookup.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_time_lookup
// Self-checking testbench for the breakpoint lookup table. A short directed
// table covers the empty table, the clamps at both ends, the extreme times,
// values and slots, and unsorted breakpoints. Random phases then rewrite the
// table with sorted spread or dense times and query it under many
// breakpoint counts, up to and past the depth. Every query result is
// compared with its directed expected value or an in-bench interpolation
// model while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_time_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import plt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int ITEM_TARGET  = 1800;
  localparam int WRITE_SETTLE = 4;
  localparam int DRAIN_CYCLES = 50;

  localparam logic signed [DATA_W-1:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] T_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic                     ok;
    logic signed [DATA_W-1:0] value;
  } lookup_result_t;

  typedef struct {
    logic                     is_cfg;
    logic [COUNT_W-1:0]       count;
    logic                     op;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] bp_t;
    logic signed [DATA_W-1:0] bp_v;
    logic signed [DATA_W-1:0] q_t;
    logic                     known;
    lookup_result_t           res;
  } stim_row_t;

  logic                     clk               = 1'b0;
  logic                     rst_n             = 1'b0;
  logic                     in_valid          = 1'b0;
  logic                     in_stall;
  logic                     in_op             = OP_WRITE;
  logic [INDEX_W-1:0]       in_point_index    = '0;
  logic signed [DATA_W-1:0] in_point_time     = '0;
  logic signed [DATA_W-1:0] in_point_value    = '0;
  logic signed [DATA_W-1:0] in_query_time     = '0;
  logic                     out_valid;
  logic                     out_stall         = 1'b0;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_result_value;
  logic                     cfg_valid         = 1'b0;
  logic                     cfg_ready;
  logic [COUNT_W-1:0]       cfg_points_in_use = '0;

  logic signed [DATA_W-1:0] bp_time  [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_value [TABLE_DEPTH];
  logic [COUNT_W-1:0]       points_cfg = '0;
  lookup_result_t           expected_results [$];
  lookup_result_t           no_result = '{1'b0, '0};

  bit no_idle     = 1'b0;
  int stall_left  = 0;
  int items_sent  = 0;
  int error_count = 0;

  piecewise_linear_time_lookup i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_point_index   (in_point_index),
    .in_point_time    (in_point_time),
    .in_point_value   (in_point_value),
    .in_query_time    (in_query_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_result_value (out_result_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_points_in_use(cfg_points_in_use)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int active_points();
    return (points_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(points_cfg);
  endfunction

  function automatic lookup_result_t predict_lookup(input logic signed [DATA_W-1:0] q);
    lookup_result_t r;
    int     n;
    int     lo;
    int     hi;
    int     mid;
    longint span;
    longint offset;
    longint alpha;
    longint diff;
    r.ok    = 1'b0;
    r.value = '0;
    n       = active_points();
    if (n == 0) return r;
    r.ok = 1'b1;
    if (q <= bp_time[0]) begin
      r.value = bp_value[0];
    end else if (q >= bp_time[n-1]) begin
      r.value = bp_value[n-1];
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (bp_time[mid] <= q) lo = mid;
        else hi = mid;
      end
      span   = longint'(bp_time[hi]) - longint'(bp_time[lo]);
      offset = longint'(q) - longint'(bp_time[lo]);
      if (span <= 0) begin
        r.value = bp_value[lo];
      end else begin
        if (offset <= 0) alpha = 0;
        else if (offset >= span) alpha = longint'(1) <<< FRAC_BITS;
        else alpha = (offset <<< FRAC_BITS) / span;
        diff    = longint'(bp_value[hi]) - longint'(bp_value[lo]);
        r.value = DATA_W'(longint'(bp_value[lo]) + ((diff * alpha) >>> FRAC_BITS));
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint rand_below(input longint width);
    return longint'({$urandom, $urandom} % width);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_query_time();
    int     n;
    int     k;
    int     r;
    longint lo_t;
    longint hi_t;
    n = active_points();
    r = $urandom_range(0, 99);
    if (n == 0 || r < 10) return $urandom;
    if (r < 17) return ($urandom_range(0, 1) != 0) ? T_MAX : T_MIN;
    if (r < 25 || n == 1) return bp_time[$urandom_range(0, n - 1)];
    k    = $urandom_range(0, n - 2);
    lo_t = bp_time[k];
    hi_t = bp_time[k+1];
    if (hi_t <= lo_t) return bp_time[k];
    return DATA_W'(lo_t + rand_below(hi_t - lo_t + 1));
  endfunction

  function automatic stim_row_t cfg_row(input logic [COUNT_W-1:0] count);
    stim_row_t s;
    s        = '{1'b1, count, OP_WRITE, '0, '0, '0, '0, 1'b0, '{1'b0, '0}};
    return s;
  endfunction

  function automatic stim_row_t write_row(input logic [INDEX_W-1:0] idx,
                                          input logic signed [DATA_W-1:0] t,
                                          input logic signed [DATA_W-1:0] v);
    stim_row_t s;
    s = '{1'b0, '0, OP_WRITE, idx, t, v, '0, 1'b0, '{1'b0, '0}};
    return s;
  endfunction

  function automatic stim_row_t query_row(input logic signed [DATA_W-1:0] q);
    stim_row_t s;
    s = '{1'b0, '0, OP_QUERY, '0, '0, '0, q, 1'b0, '{1'b0, '0}};
    return s;
  endfunction

  function automatic stim_row_t query_row_known(input logic signed [DATA_W-1:0] q,
                                                input logic ok,
                                                input logic signed [DATA_W-1:0] v);
    stim_row_t s;
    s = '{1'b0, '0, OP_QUERY, '0, '0, '0, q, 1'b1, '{ok, v}};
    return s;
  endfunction

  task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] pt,
                           input logic signed [DATA_W-1:0] pv,
                           input logic signed [DATA_W-1:0] qt,
                           input logic known, input lookup_result_t known_res);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_point_index <= idx;
    in_point_time  <= pt;
    in_point_value <= pv;
    in_query_time  <= qt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_WRITE) begin
      bp_time[idx]  = pt;
      bp_value[idx] = pv;
    end else if (known) begin
      expected_results.push_back(known_res);
    end else begin
      expected_results.push_back(predict_lookup(qt));
    end
    @(negedge clk);
  endtask

  // Change the count only once the block has drained.
  task automatic set_points(input logic [COUNT_W-1:0] count);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_points_in_use <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    points_cfg = count;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_write();
    int                       k;
    longint                   lb;
    longint                   ub;
    logic signed [DATA_W-1:0] t;
    k = $urandom_range(0, TABLE_DEPTH - 1);
    if ($urandom_range(0, 99) < 15) begin
      t = $urandom;
    end else begin
      lb = (k == 0) ? longint'(T_MIN) : longint'(bp_time[k-1]);
      ub = (k == TABLE_DEPTH - 1) ? longint'(T_MAX) : longint'(bp_time[k+1]);
      t  = (lb <= ub) ? DATA_W'(lb + rand_below(ub - lb + 1)) : bp_time[k];
    end
    send_item(OP_WRITE, INDEX_W'(k), t, $urandom, $urandom, 1'b0, no_result);
  endtask

  // Rewrite every slot with non-decreasing times, spread over the full range or dense.
  task automatic refill_table(input bit dense);
    longint t_acc;
    longint t;
    t_acc = longint'($urandom_range(0, 1 << 21)) - (longint'(1) << 20);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (dense) begin
        if ($urandom_range(0, 3) != 0) t_acc += $urandom_range(1, 'h3_0000);
        t = t_acc;
      end else begin
        t = -(longint'(1) << 31) + (longint'(i) << 24) + $urandom_range(0, (1 << 24) - 1);
      end
      send_item(OP_WRITE, INDEX_W'(i), DATA_W'(t), $urandom, $urandom, 1'b0, no_result);
    end
  endtask

  always @(negedge clk) begin
    if (no_idle) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left--;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction ok %b result_value %h",
                 $time, out_ok, out_result_value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %b got %b", $time, want.ok, out_ok);
          error_count++;
        end
        if (out_result_value !== want.value) begin
          $display("%0t: result_value expected %h got %h",
                   $time, want.value, out_result_value);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed [$];
    int        phase;
    int        n_items;
    logic [COUNT_W-1:0] count;
    directed = '{
      cfg_row(9'd0),
      query_row_known(32'sd0, 1'b0, 32'sd0),
      query_row_known(T_MIN, 1'b0, 32'sd0),
      write_row(8'd0, T_MIN, T_MAX),
      write_row(8'd255, T_MAX, T_MIN),
      cfg_row(9'd1),
      query_row_known(T_MIN, 1'b1, T_MAX),
      query_row_known(T_MAX, 1'b1, T_MAX),
      write_row(8'd1, T_MAX, T_MIN),
      cfg_row(9'd2),
      query_row_known(T_MIN, 1'b1, T_MAX),
      query_row_known(T_MAX, 1'b1, T_MIN),
      query_row(32'sd0),
      query_row(-32'sd1),
      query_row(T_MAX - 32'sd1),
      write_row(8'd0, 32'sd0, 32'sd0),
      write_row(8'd1, 32'sh0008_0000, T_MIN),
      write_row(8'd2, 32'sh0005_0000, 32'sh0064_0000),
      write_row(8'd3, 32'sh000A_0000, T_MAX),
      cfg_row(9'd4),
      query_row(32'sh0003_0000),
      query_row(32'sh0009_0000),
      query_row(32'sh0005_0000),
      query_row_known(32'sd0, 1'b1, 32'sd0),
      query_row_known(32'sh000A_0000, 1'b1, T_MAX)
    };
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_points(directed[i].count);
      end else begin
        send_item(directed[i].op, directed[i].index, directed[i].bp_t, directed[i].bp_v,
                  directed[i].q_t, directed[i].known, directed[i].res);
      end
    end

    refill_table(1'b0);
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase % 6 == 5) refill_table(((phase / 6) % 2) == 0);
      case ($urandom_range(0, 9))
        0:       count = 9'd0;
        1:       count = 9'd1;
        2:       count = 9'd2;
        3:       count = COUNT_W'($urandom_range(3, 8));
        4:       count = COUNT_W'($urandom_range(9, 254));
        5, 6:    count = 9'd256;
        7:       count = 9'd255;
        8:       count = COUNT_W'($urandom_range(257, 510));
        default: count = 9'd511;
      endcase
      set_points(count);
      no_idle = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(40, 120);
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 80) begin
          send_item(OP_QUERY, INDEX_W'($urandom), $urandom, $urandom, pick_query_time(),
                    1'b0, no_result);
        end else begin
          random_write();
        end
      end
      phase++;
    end

    no_idle  = 1'b0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #15ms;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
